### rtl/efr_pkg.sv
package efr_pkg;

  // sizes and fixed field widths
  localparam int unsigned FRAME_BYTES_DEF = 64;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned RATE_W          = 7;
  localparam int unsigned TALLY_W         = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned RATE_WINDOW     = 10;

  // crc-8, reflected form
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

  // register reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'h03;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'h10;
  localparam logic [BYTE_W-1:0] ESCAPE_MASK_RST = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE  = 2'd0,
    CFG_END_BYTE    = 2'd1,
    CFG_ESCAPE_BYTE = 2'd2,
    CFG_ESCAPE_MASK = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_BAD      = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_EMPTY_OK = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } ctrl_state_e;

  typedef enum logic [1:0] {
    UN_IDLE,
    UN_RUN,
    UN_DONE
  } unstuff_state_e;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_DATA,
    EM_STAT
  } emit_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escape_mask;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic bad;
  } walk_status_t;

  typedef struct packed {
    logic              start;
    kind_e             kind;
    logic [LEN_W-1:0]  len;
    logic [RATE_W-1:0] rate;
  } emit_cmd_t;

  // one byte of the reflected crc, one shift per bit
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/efr_unstuff.sv
module efr_unstuff import efr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int unsigned IDX_W = $clog2(FRAME_BYTES),
  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              store_en_i,
  input  logic [IDX_W-1:0]  store_addr_i,
  input  logic [BYTE_W-1:0] store_data_i,
  input  logic              walk_start_i,
  input  logic [CNT_W-1:0]  walk_total_i,
  output walk_status_t      walk_status_o,
  output logic [CNT_W-1:0]  plen_o,
  output logic              pay_we_o,
  output logic [IDX_W-1:0]  pay_addr_o,
  output logic [BYTE_W-1:0] pay_data_o
);

  logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rd_data_q;

  unstuff_state_e    state_q, state_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              esc_q, esc_d;
  logic [CNT_W-1:0]  plen_q, plen_d;
  logic [BYTE_W-1:0] crc_q, crc_d;
  logic [BYTE_W-1:0] last_q, last_d;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              is_marker;
  logic              is_escape;
  logic              push;
  logic [BYTE_W-1:0] ubyte;

  // raw frame memory: written while receiving, read during the walk
  always_ff @(posedge clk_i) begin
    if (store_en_i) begin
      frame_mem[store_addr_i] <= store_data_i;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      UN_IDLE: if (walk_start_i) state_d = UN_RUN;
      UN_RUN:  if ((rd_idx_q == total_q) && !rd_vld_q) state_d = UN_DONE;
      UN_DONE: state_d = UN_IDLE;
      default: state_d = UN_IDLE;
    endcase
  end

  // outputs of the walk
  always_comb begin
    rd_en                = (state_q == UN_RUN) && (rd_idx_q != total_q);
    rd_addr              = rd_idx_q[IDX_W-1:0];
    walk_status_o.done   = (state_q == UN_DONE);
    walk_status_o.bad    = esc_q || (plen_q == '0) || (crc_q != last_q);
    plen_o               = plen_q;
  end

  // classify the byte read last cycle; markers win over escape
  always_comb begin
    is_marker  = (rd_data_q == cfg_i.start_byte) || (rd_data_q == cfg_i.end_byte);
    is_escape  = (rd_data_q == cfg_i.escape_byte);
    ubyte      = esc_q ? (rd_data_q ^ cfg_i.escape_mask) : rd_data_q;
    push       = rd_vld_q && (esc_q || (!is_marker && !is_escape));
    pay_we_o   = push;
    pay_addr_o = plen_q[IDX_W-1:0];
    pay_data_o = ubyte;
  end

  // walk datapath: read pointer, escape flag, payload count, crc of all but the last byte
  always_comb begin
    total_d  = total_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    esc_d    = esc_q;
    plen_d   = plen_q;
    crc_d    = crc_q;
    last_d   = last_q;
    if ((state_q == UN_IDLE) && walk_start_i) begin
      total_d  = walk_total_i;
      rd_idx_d = '0;
      esc_d    = 1'b0;
      plen_d   = '0;
      crc_d    = '0;
    end else if (state_q == UN_RUN) begin
      rd_vld_d = rd_en;
      if (rd_en) begin
        rd_idx_d = rd_idx_q + CNT_W'(1);
      end
      if (rd_vld_q) begin
        esc_d = !esc_q && !is_marker && is_escape;
      end
      if (push) begin
        plen_d = plen_q + CNT_W'(1);
        last_d = ubyte;
        if (plen_q != '0) begin
          crc_d = crc8_byte(crc_q, last_q);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= UN_IDLE;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      esc_q    <= 1'b0;
      plen_q   <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_vld_d;
      esc_q    <= esc_d;
      plen_q   <= plen_d;
      total_q  <= total_d;
    end
  end

  // crc datapath
  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    last_q <= last_d;
  end

endmodule

### rtl/efr_emit.sv
module efr_emit import efr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int unsigned IDX_W = $clog2(FRAME_BYTES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pay_we_i,
  input  logic [IDX_W-1:0]  pay_addr_i,
  input  logic [BYTE_W-1:0] pay_data_i,
  input  emit_cmd_t         cmd_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic              last_of_run_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic [RATE_W-1:0] success_rate_o
);

  logic [BYTE_W-1:0] pay_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rd_data_q;

  emit_state_e       state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [LEN_W-1:0]  idx_q, idx_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic [RATE_W-1:0] out_rate_q, out_rate_d;

  logic out_free;
  logic last_byte;
  logic rd_en;
  logic load;

  // unstuffed payload memory
  always_ff @(posedge clk_i) begin
    if (pay_we_i) begin
      pay_mem[pay_addr_i] <= pay_data_i;
    end
    if (rd_en) begin
      rd_data_q <= pay_mem[idx_q[IDX_W-1:0]];
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_byte = (idx_q == (len_q - LEN_W'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EM_IDLE: begin
        if (cmd_i.start) begin
          state_d = (cmd_i.kind == KIND_PAYLOAD) ? EM_READ : EM_STAT;
        end
      end
      EM_READ: state_d = EM_DATA;
      EM_DATA: if (out_free) state_d = last_byte ? EM_IDLE : EM_READ;
      EM_STAT: if (out_free) state_d = EM_IDLE;
      default: state_d = EM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy_o = (state_q != EM_IDLE);
    rd_en  = (state_q == EM_READ);
    load   = out_free && ((state_q == EM_DATA) || (state_q == EM_STAT));
  end

  // command latch and byte index
  always_comb begin
    kind_d = kind_q;
    len_d  = len_q;
    rate_d = rate_q;
    idx_d  = idx_q;
    if ((state_q == EM_IDLE) && cmd_i.start) begin
      kind_d = cmd_i.kind;
      len_d  = cmd_i.len;
      rate_d = cmd_i.rate;
      idx_d  = '0;
    end else if (load && (state_q == EM_DATA)) begin
      idx_d = idx_q + LEN_W'(1);
    end
  end

  // output register, freed by the downstream transfer
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_len_d   = out_len_q;
    out_rate_d  = out_rate_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_rate_d  = rate_q;
      if (state_q == EM_DATA) begin
        out_kind_d = KIND_PAYLOAD;
        out_byte_d = rd_data_q;
        out_last_d = last_byte;
        out_len_d  = len_q;
      end else begin
        out_kind_d = kind_q;
        out_byte_d = '0;
        out_last_d = 1'b1;
        out_len_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EM_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    len_q      <= len_d;
    rate_q     <= rate_d;
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_len_q  <= out_len_d;
    out_rate_q <= out_rate_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign payload_byte_o = out_byte_q;
  assign last_of_run_o  = out_last_q;
  assign frame_length_o = out_len_q;
  assign success_rate_o = out_rate_q;

endmodule

### rtl/escaped_frame_receiver_crc8_core.sv
// data path: a byte that is only stored is written to frame memory; an end byte starts
//   a walk over the n stored bytes, then each payload result passes the payload memory
//   read and the output register load, and a status result only the output register load
// throughput: one byte per cycle while a frame is filled; input waits during the walk
//   and until the last result of a run sits in the output register
// reset: control state, counters and rate clear, registers take their defaults;
//   frame memory contents stay undefined and are never read before written
module escaped_frame_receiver_crc8_core import efr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic                 last_of_run_o,
  output logic [LEN_W-1:0]     frame_length_o,
  output logic [RATE_W-1:0]    success_rate_o
);

  localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);

  cfg_t               cfg_q, cfg_d;
  ctrl_state_e        state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [TALLY_W-1:0] good_q, good_d;
  logic [TALLY_W-1:0] bad_q, bad_d;
  logic [RATE_W-1:0]  rate_q, rate_d;

  logic               accept;
  logic               ovf;
  logic [CNT_W-1:0]   fill_base;
  logic               is_start;
  logic               is_end;
  logic               store_en;
  logic [IDX_W-1:0]   store_addr;
  logic               walk_start;
  logic [CNT_W-1:0]   walk_total;
  walk_status_t       walk_status;
  logic [CNT_W-1:0]   plen;
  logic               pay_we;
  logic [IDX_W-1:0]   pay_addr;
  logic [BYTE_W-1:0]  pay_data;
  emit_cmd_t          emit_cmd;
  logic               emit_busy;
  logic               ev_good;
  logic               ev_bad;
  logic [TALLY_W-1:0] good_inc;
  logic [TALLY_W-1:0] bad_inc;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_BYTE:  cfg_d.start_byte  = cfg_data_i;
        CFG_END_BYTE:    cfg_d.end_byte    = cfg_data_i;
        CFG_ESCAPE_BYTE: cfg_d.escape_byte = cfg_data_i;
        CFG_ESCAPE_MASK: cfg_d.escape_mask = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (walk_start) state_d = ST_WALK;
      ST_WALK: if (walk_status.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake
  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && !emit_busy;
  end

  assign accept = in_valid_i && in_ready_o;

  // receive: overflow drop first, then the byte is handled against the fill level
  always_comb begin
    ovf        = (fill_q == CNT_W'(FRAME_BYTES));
    fill_base  = ovf ? '0 : fill_q;
    is_start   = (rx_byte_i == cfg_q.start_byte);
    is_end     = (rx_byte_i == cfg_q.end_byte);
    store_en   = accept && ((fill_base == '0) ? is_start : 1'b1);
    store_addr = fill_base[IDX_W-1:0];
    walk_start = accept && (fill_base != '0) && is_end;
    walk_total = fill_base + CNT_W'(1);
    fill_d     = fill_q;
    if (accept) begin
      if (fill_base == '0) begin
        fill_d = is_start ? CNT_W'(1) : '0;
      end else if (is_end) begin
        fill_d = '0;
      end else begin
        fill_d = fill_base + CNT_W'(1);
      end
    end
  end

  // frame tallies and success rate over a window of frames
  always_comb begin
    ev_bad   = (accept && ovf) || (walk_status.done && walk_status.bad);
    ev_good  = walk_status.done && !walk_status.bad;
    good_inc = good_q + TALLY_W'(ev_good);
    bad_inc  = bad_q + TALLY_W'(ev_bad);
    good_d   = good_inc;
    bad_d    = bad_inc;
    rate_d   = rate_q;
    if (({1'b0, good_inc} + {1'b0, bad_inc}) >= (TALLY_W + 1)'(RATE_WINDOW)) begin
      rate_d = RATE_W'({good_inc, 3'b000}) + RATE_W'({good_inc, 1'b0});
      good_d = '0;
      bad_d  = '0;
    end
  end

  // result run request
  always_comb begin
    emit_cmd.start = (accept && ovf) || walk_status.done;
    emit_cmd.rate  = rate_d;
    emit_cmd.len   = '0;
    if (accept && ovf) begin
      emit_cmd.kind = KIND_OVERFLOW;
    end else if (walk_status.bad) begin
      emit_cmd.kind = KIND_BAD;
    end else if (plen == CNT_W'(1)) begin
      emit_cmd.kind = KIND_EMPTY_OK;
    end else begin
      emit_cmd.kind = KIND_PAYLOAD;
      emit_cmd.len  = LEN_W'(plen - CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= START_BYTE_RST;
      cfg_q.end_byte    <= END_BYTE_RST;
      cfg_q.escape_byte <= ESCAPE_BYTE_RST;
      cfg_q.escape_mask <= ESCAPE_MASK_RST;
      state_q           <= ST_IDLE;
      fill_q            <= '0;
      good_q            <= '0;
      bad_q             <= '0;
      rate_q            <= '0;
    end else begin
      cfg_q   <= cfg_d;
      state_q <= state_d;
      fill_q  <= fill_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
      rate_q  <= rate_d;
    end
  end

  // frame memory and unstuffing walk
  efr_unstuff #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_unstuff (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .store_en_i    (store_en),
    .store_addr_i  (store_addr),
    .store_data_i  (rx_byte_i),
    .walk_start_i  (walk_start),
    .walk_total_i  (walk_total),
    .walk_status_o (walk_status),
    .plen_o        (plen),
    .pay_we_o      (pay_we),
    .pay_addr_o    (pay_addr),
    .pay_data_o    (pay_data)
  );

  // payload memory and result output register
  efr_emit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_emit (
    .clk_i,
    .rst_ni,
    .pay_we_i       (pay_we),
    .pay_addr_i     (pay_addr),
    .pay_data_i     (pay_data),
    .cmd_i          (emit_cmd),
    .busy_o         (emit_busy),
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .payload_byte_o,
    .last_of_run_o,
    .frame_length_o,
    .success_rate_o
  );

  // fill level never passes the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(FRAME_BYTES))
    else $error("fill level beyond frame buffer");

  // tallies are folded into the rate before they reach the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, good_q} + {1'b0, bad_q}) < (TALLY_W + 1)'(RATE_WINDOW))
    else $error("frame tally not cleared at window");

  // the walk finishes only while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_status.done |-> state_q == ST_WALK)
    else $error("walk done outside walk state");

  // a result run is only requested when the emitter is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cmd.start |-> !emit_busy)
    else $error("result run requested while emitter busy");

endmodule

### test/escaped_frame_receiver_crc8_core_check.sv
`timescale 1ns / 1ps

module escaped_frame_receiver_crc8_core_check import efr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           kind_i,
  input  logic [BYTE_W-1:0]    payload_byte_i,
  input  logic                 last_of_run_i,
  input  logic [LEN_W-1:0]     frame_length_i,
  input  logic [RATE_W-1:0]    success_rate_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [RATE_W-1:0] rate;
  } rx_result_t;

  // mirror of the block: registers, frame memory, tallies
  cfg_t              regs;
  logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
  int unsigned       fill;
  int unsigned       good_cnt;
  int unsigned       bad_cnt;
  logic [RATE_W-1:0] rate_val;
  rx_result_t        result_q [$];

  // reflected crc-8, one bit at a time from the lsb
  function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] acc;
    logic              lsb;
    acc = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      lsb = acc[0];
      acc = acc >> 1;
      if (lsb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // count a finished frame, refresh the rate once a window is full
  task automatic count_frame(input bit good);
    if (good) good_cnt++;
    else bad_cnt++;
    if (good_cnt + bad_cnt >= RATE_WINDOW) begin
      rate_val = RATE_W'(good_cnt * 100 / RATE_WINDOW);
      good_cnt = 0;
      bad_cnt  = 0;
    end
  endtask

  task automatic store_raw(input logic [BYTE_W-1:0] c);
    if (fill < FRAME_BYTES) begin
      frame_mem[fill] = c;
      fill++;
    end
  endtask

  // expected results for one accepted link byte
  task automatic absorb_byte(input logic [BYTE_W-1:0] c);
    rx_result_t        run [$];
    logic [BYTE_W-1:0] plain [$];
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] crc;
    rx_result_t        r;
    int unsigned       i;
    bit                bad;
    r = '0;
    // full store: drop the frame, then treat the byte as if idle
    if (fill >= FRAME_BYTES) begin
      fill = 0;
      count_frame(1'b0);
      r.kind = KIND_OVERFLOW;
      run.push_back(r);
    end
    if (fill == 0) begin
      if (c == regs.start_byte) store_raw(c);
    end else if (c == regs.end_byte) begin
      store_raw(c);
      bad = 1'b0;
      i   = 0;
      // unstuff: markers vanish, an escape flips the byte after it
      while (i < fill && !bad) begin
        b = frame_mem[i];
        if (b == regs.start_byte || b == regs.end_byte) begin
          i++;
        end else if (b == regs.escape_byte) begin
          if (i + 1 >= fill) bad = 1'b1;
          else plain.push_back(frame_mem[i+1] ^ regs.escape_mask);
          i += 2;
        end else begin
          plain.push_back(b);
          i++;
        end
      end
      if (!bad) begin
        if (plain.size() == 0) begin
          bad = 1'b1;
        end else begin
          crc = '0;
          for (int k = 0; k + 1 < plain.size(); k++) crc = crc_step(crc, plain[k]);
          if (crc != plain[$]) bad = 1'b1;
        end
      end
      fill = 0;
      count_frame(!bad);
      if (bad) begin
        r.kind = KIND_BAD;
        run.push_back(r);
      end else if (plain.size() == 1) begin
        r.kind = KIND_EMPTY_OK;
        run.push_back(r);
      end else begin
        for (int k = 0; k + 1 < plain.size(); k++) begin
          r.kind = KIND_PAYLOAD;
          r.data = plain[k];
          r.len  = LEN_W'(plain.size() - 1);
          run.push_back(r);
        end
      end
    end else begin
      store_raw(c);
    end
    // rate after the byte is handled, last flag on the final one
    foreach (run[k]) begin
      r      = run[k];
      r.rate = rate_val;
      r.last = (k == run.size() - 1);
      result_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    rx_result_t r;
    if (!rst_ni) begin
      regs      = '{START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_MASK_RST};
      fill      = 0;
      good_cnt  = 0;
      bad_cnt   = 0;
      rate_val  = '0;
      result_q.delete();
      errors_o  = 0;
    end else begin
      // output transfer first, so a same-edge input cannot feed it
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: kind %0d, byte %0d", kind_i, payload_byte_i);
          errors_o++;
        end else begin
          r = result_q.pop_front();
          check_field("kind", 8'(r.kind), 8'(kind_i));
          check_field("payload_byte", r.data, payload_byte_i);
          check_field("last_of_run", 8'(r.last), 8'(last_of_run_i));
          check_field("frame_length", 8'(r.len), 8'(frame_length_i));
          check_field("success_rate", 8'(r.rate), 8'(success_rate_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_START_BYTE:  regs.start_byte  = cfg_data_i;
          CFG_END_BYTE:    regs.end_byte    = cfg_data_i;
          CFG_ESCAPE_BYTE: regs.escape_byte = cfg_data_i;
          CFG_ESCAPE_MASK: regs.escape_mask = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) absorb_byte(rx_byte_i);
    end
    pending_o = result_q.size();
  end

endmodule

### test/escaped_frame_receiver_crc8_core_test.sv
`timescale 1ns / 1ps

module escaped_frame_receiver_crc8_core_test;
  import efr_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [BYTE_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    rx_byte_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           kind_o;
  logic [BYTE_W-1:0]    payload_byte_o;
  logic                 last_of_run_o;
  logic [LEN_W-1:0]     frame_length_o;
  logic [RATE_W-1:0]    success_rate_o;
  int unsigned          errors;
  int unsigned          pending;

  // register values as last written, used to build frames
  cfg_t              link_cfg;
  bit                in_gaps_on  = 1'b1;
  bit                out_gaps_on = 1'b1;
  int unsigned       hold_reqs   = 0;
  int unsigned       frame_bytes = 0;
  logic [BYTE_W-1:0] body_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  escaped_frame_receiver_crc8_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .payload_byte_o,
    .last_of_run_o,
    .frame_length_o,
    .success_rate_o
  );

  escaped_frame_receiver_crc8_core_check frame_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .rx_byte_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .kind_i         (kind_o),
    .payload_byte_i (payload_byte_o),
    .last_of_run_i  (last_of_run_o),
    .frame_length_i (frame_length_o),
    .success_rate_i (success_rate_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // result side: random stalls plus a long hold-off on request
  initial begin : out_side
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_done != hold_reqs) begin
        holds_done++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(out_gaps_on && $urandom_range(0, 99) < 22);
      end
    end
  end

  // one byte transfer on the link side, idle cycles drawn one at a time first
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (in_gaps_on && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [BYTE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_START_BYTE:  link_cfg.start_byte  = val;
      CFG_END_BYTE:    link_cfg.end_byte    = val;
      CFG_ESCAPE_BYTE: link_cfg.escape_byte = val;
      CFG_ESCAPE_MASK: link_cfg.escape_mask = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] m);
    write_reg(CFG_START_BYTE, s);
    write_reg(CFG_END_BYTE, e);
    write_reg(CFG_ESCAPE_BYTE, x);
    write_reg(CFG_ESCAPE_MASK, m);
    cfg_we_i <= 1'b0;
  endtask

  // drain all results, then give the block time to go quiet
  task automatic settle;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic bit needs_escape(input logic [BYTE_W-1:0] b);
    return b == link_cfg.start_byte || b == link_cfg.end_byte || b == link_cfg.escape_byte;
  endfunction

  // an escaped byte must not look like the end byte on the wire
  function automatic bit can_send(input logic [BYTE_W-1:0] b);
    return !needs_escape(b) ||
           (link_cfg.escape_byte != link_cfg.start_byte &&
            link_cfg.escape_byte != link_cfg.end_byte &&
            (b ^ link_cfg.escape_mask) != link_cfg.end_byte);
  endfunction

  function automatic logic [BYTE_W-1:0] body_crc;
    logic [BYTE_W-1:0] crc;
    crc = '0;
    foreach (body_q[k]) begin
      crc ^= body_q[k];
      repeat (BYTE_W) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  // random byte, leaning toward the marker values
  function automatic logic [BYTE_W-1:0] pick_byte(input bit plain_only);
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 7))
      0:       b = link_cfg.start_byte;
      1:       b = link_cfg.end_byte;
      2:       b = link_cfg.escape_byte;
      default: b = 8'($urandom);
    endcase
    while (plain_only && needs_escape(b)) b = 8'($urandom);
    return b;
  endfunction

  // payload that survives stuffing under the current markers
  function automatic void build_body(input int unsigned len, input bit plain_only);
    int unsigned tries;
    bit          ok;
    ok    = 1'b0;
    tries = 0;
    while (!ok && tries < 20) begin
      body_q.delete();
      repeat (len) body_q.push_back(pick_byte(plain_only));
      ok = plain_only ? !needs_escape(body_crc()) : can_send(body_crc());
      foreach (body_q[k]) ok = ok && can_send(body_q[k]);
      tries++;
    end
  endfunction

  // start, stuffed payload and crc, end
  task automatic send_frame(input bit spoil);
    logic [BYTE_W-1:0] crc;
    int unsigned       sent;
    crc = body_crc();
    if (spoil) crc ^= 8'($urandom_range(1, 255));
    body_q.push_back(crc);
    sent = 2;
    send_byte(link_cfg.start_byte);
    foreach (body_q[k]) begin
      if (needs_escape(body_q[k])) begin
        send_byte(link_cfg.escape_byte);
        send_byte(body_q[k] ^ link_cfg.escape_mask);
        sent += 2;
      end else begin
        send_byte(body_q[k]);
        sent++;
      end
    end
    send_byte(link_cfg.end_byte);
    frame_bytes += sent;
  endtask

  // mostly good frames, some bad crc, raw junk frames and idle noise
  task automatic random_traffic(input int unsigned budget);
    int unsigned stop;
    int unsigned pick;
    int unsigned n;
    stop = frame_bytes + budget;
    while (frame_bytes < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_body($urandom_range(0, 9) == 0 ? $urandom_range(7, 20) : $urandom_range(0, 6),
                   1'b0);
        send_frame(1'b0);
      end else if (pick < 80) begin
        build_body($urandom_range(0, 6), 1'b0);
        send_frame(1'b1);
      end else if (pick < 92) begin
        n = $urandom_range(0, 6);
        send_byte(link_cfg.start_byte);
        repeat (n) send_byte(8'($urandom));
        if ($urandom_range(0, 1) == 1) send_byte(link_cfg.escape_byte);
        send_byte(link_cfg.end_byte);
        frame_bytes += n + 3;
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] fill_byte;
    link_cfg = '{START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_MASK_RST};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes outside a frame are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    // frame with nothing inside
    send_byte(link_cfg.start_byte);
    send_byte(link_cfg.end_byte);
    // good frame holding only the check byte
    body_q.delete();
    send_frame(1'b0);
    // byte extremes and every marker value, escaped
    body_q = '{8'h00, 8'hFF, link_cfg.start_byte, link_cfg.end_byte, link_cfg.escape_byte};
    send_frame(1'b0);
    // check byte mismatch
    body_q = '{8'h5A};
    send_frame(1'b1);
    // escape right before the end byte
    send_byte(link_cfg.start_byte);
    send_byte(link_cfg.escape_byte);
    send_byte(link_cfg.end_byte);

    // back to back, no gaps: good and bad frames close a rate window
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    repeat (5) begin
      body_q.delete();
      send_frame(1'b0);
    end
    repeat (5) begin
      send_byte(link_cfg.start_byte);
      send_byte(link_cfg.end_byte);
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;

    // long receiver hold-off while a long frame and more arrive
    hold_reqs++;
    build_body(12, 1'b1);
    send_frame(1'b0);
    // fill the store, then a start byte drops it and opens a new frame
    send_byte(link_cfg.start_byte);
    repeat (63) begin
      fill_byte = 8'($urandom);
      while (fill_byte == link_cfg.end_byte) fill_byte = 8'($urandom);
      send_byte(fill_byte);
    end
    build_body(3, 1'b0);
    send_frame(1'b0);
    random_traffic(5);
    settle();

    // markers at the byte extremes, full mask
    set_markers(8'h00, 8'hFF, 8'h7D, 8'hFF);
    random_traffic(5);
    settle();

    // escape equal to the end byte, zero mask
    set_markers(8'hFF, 8'h00, 8'h00, 8'h00);
    random_traffic(5);
    settle();

    // one value opens and closes frames
    set_markers(8'hAA, 8'hAA, 8'h55, 8'h80);
    random_traffic(5);
    settle();

    set_markers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(5);
    settle();

    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
